// ----- design/tgc_pkg.sv -----
// ============================================================================
// tgc_pkg
// Shared types and constants for the toy Grain-style stream cipher core.
// ============================================================================
`default_nettype none

package tgc_pkg;

   // Operation codes carried by each input transaction
   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_INIT      = 2'd1,
      OP_INVERSE   = 2'd2,
      OP_KEYSTREAM = 2'd3
   } op_type;

   // Fixed fill of linear cells 4..7 on a load
   localparam logic [3:0] LIN_TAIL = 4'b0101;

   // Both cipher registers, cell 0 of each as its MSB
   typedef struct packed {
      logic [7:0] nonlinear;
      logic [7:0] linear;
   } cipher_state_type;

endpackage : tgc_pkg

`default_nettype wire

// ----- design/tgc_step.sv -----
// ============================================================================
// tgc_step
// Combinational next-state and filter logic for one cipher operation.
// ============================================================================
`default_nettype none

module tgc_step (
   input  tgc_pkg::op_type           operation,
   input  logic [7:0]                key,
   input  logic [3:0]                init_vector,
   input  tgc_pkg::cipher_state_type state_cur,
   output tgc_pkg::cipher_state_type state_nxt,
   output logic                      keystream_bit
);
   import tgc_pkg::*;

   // Cell views: index 0 is the register MSB
   logic [0:7] nc;
   logic [0:7] lc;
   logic [0:7] ns;
   logic [0:7] ls;
   logic       h_fwd;
   logic       h_inv;
   logic       f_fwd;
   logic       g_fwd;
   logic       nb_fwd;
   logic       lb_fwd;
   logic       l0_inv;
   logic       n0_inv;

   assign nc = state_cur.nonlinear;
   assign lc = state_cur.linear;

   // Cells after a shift toward cell 7 (cell 0 kept)
   assign ns = {nc[0], nc[0:6]};
   assign ls = {lc[0], lc[0:6]};

   // Forward clock: filter and feedback on current cells
   assign h_fwd = (nc[4] & lc[2]) ^ (nc[7] & lc[6]) ^ nc[2] ^ nc[4] ^ nc[7] ^ lc[5];
   assign f_fwd = lc[0] ^ lc[1] ^ lc[6] ^ lc[7];
   assign g_fwd = nc[0] ^ nc[2] ^ nc[3] ^ (nc[3] & nc[5]) ^ (nc[1] & nc[2])
                ^ (nc[4] & nc[6]);
   assign nb_fwd = g_fwd ^ lc[0] ^ ((operation == OP_INIT) & h_fwd);
   assign lb_fwd = f_fwd ^ ((operation == OP_INIT) & h_fwd);

   // Inverse init clock: filter on shifted cells, recover cell 0
   assign h_inv  = (ns[4] & ls[2]) ^ (ns[7] & ls[6]) ^ ns[2] ^ ns[4] ^ ns[7] ^ ls[5];
   assign l0_inv = h_inv ^ lc[7] ^ ls[1] ^ ls[6] ^ ls[7];
   assign n0_inv = h_inv ^ nc[7] ^ l0_inv ^ ns[2] ^ ns[3] ^ (ns[3] & ns[5])
                 ^ (ns[1] & ns[2]) ^ (ns[4] & ns[6]);

   // Operation select
   always_comb begin
      case (operation)
         OP_LOAD: begin
            state_nxt.nonlinear = key;
            state_nxt.linear    = {init_vector, LIN_TAIL};
            keystream_bit       = 1'b0;
         end
         OP_INVERSE: begin
            state_nxt.nonlinear = {n0_inv, state_cur.nonlinear[7:1]};
            state_nxt.linear    = {l0_inv, state_cur.linear[7:1]};
            keystream_bit       = h_inv;
         end
         OP_INIT, OP_KEYSTREAM: begin
            state_nxt.nonlinear = {state_cur.nonlinear[6:0], nb_fwd};
            state_nxt.linear    = {state_cur.linear[6:0], lb_fwd};
            keystream_bit       = h_fwd;
         end
         default: begin
            state_nxt     = state_cur;
            keystream_bit = 1'b0;
         end
      endcase
   end

endmodule : tgc_step

`default_nettype wire

// ----- design/toy_grain_cipher_core.sv -----
// ============================================================================
// toy_grain_cipher_core
// Toy Grain-style stream cipher: 8-bit nonlinear and 8-bit linear registers,
// load, init clock, inverse init clock and keystream clock operations.
// ============================================================================
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  req_     | in        | req_valid / req_ready  | operation, key, init_vector
//  rsp_     | out       | rsp_valid / rsp_ready  | keystream_bit, nonlinear_state,
//           |           |                        | linear_state
//
//  One transaction per cycle sustained while rsp_ready holds high; an accepted
//  transaction goes into the input register, then through one step of gate logic
//  into the result register, which drives rsp_valid and also updates the cipher state.
//  Synchronous active-high reset clears both cipher registers and all valids.
//  A stalled result holds its register; the input register still takes one
//  more transaction, then req_ready drops until the result drains.
//
`default_nettype none

module toy_grain_cipher_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [7:0]            req_key,
   input  logic [3:0]            req_init_vector,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_keystream_bit,
   output logic [7:0]            rsp_nonlinear_state,
   output logic [7:0]            rsp_linear_state
);
   import tgc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   op_type           in_op_ff;
   logic [7:0]       in_key_ff;
   logic [3:0]       in_iv_ff;
   cipher_state_type state_ff, state_in;
   logic             out_valid_ff, out_valid_in;
   logic             out_ks_ff;
   cipher_state_type out_state_ff;
   logic             out_free;
   logic             advance;
   logic             step_ks;

   // Pipeline flow control
   assign out_free    = !out_valid_ff || rsp_ready;
   assign advance     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || out_free;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // Step logic on the current cipher state
   tgc_step u_step (
      .operation     (in_op_ff),
      .key           (in_key_ff),
      .init_vector   (in_iv_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .keystream_bit (step_ks)
   );

   // Control state and cipher registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff  <= op_type'(req_operation);
         in_key_ff <= req_key;
         in_iv_ff  <= req_init_vector;
      end
      if (advance) begin
         out_ks_ff    <= step_ks;
         out_state_ff <= state_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_keystream_bit   = out_ks_ff;
   assign rsp_nonlinear_state = out_state_ff.nonlinear;
   assign rsp_linear_state    = out_state_ff.linear;

   // Result register always mirrors the state it just committed
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_state_ff == state_ff))
      else $error("result payload differs from committed cipher state");

   // A load gives a zero filter bit and the fixed linear tail
   a_load_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_LOAD) |=>
         (!rsp_keystream_bit && rsp_linear_state[3:0] == LIN_TAIL))
      else $error("load transaction produced wrong result");

   // Forward clocks shift the nonlinear register toward cell 0
   a_forward_shift: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_op_ff == OP_INIT || in_op_ff == OP_KEYSTREAM)) |=>
         (rsp_nonlinear_state[7:1] == $past(state_ff.nonlinear[6:0])))
      else $error("forward clock did not shift nonlinear register");

   // Input side stalls only when both stages are full and the output is held
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled without a full pipeline");

endmodule : toy_grain_cipher_core

`default_nettype wire

// ----- dv/toy_grain_cipher_core_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// toy_grain_cipher_core_test
// Self-checking bench for the toy Grain-style cipher core. Sends load, init,
// inverse init and keystream transactions with random gaps and result stalls.
// A scoreboard steps its own copy of both cipher registers and checks every
// result transaction field by field, in order.
// ============================================================================

module toy_grain_cipher_core_test;
   import tgc_pkg::*;

   localparam int ITEM_COUNT  = 550;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 18;

   // Filter bit plus both registers after the step
   typedef struct packed {
      logic             ks;
      cipher_state_type regs;
   } step_result_type;

   // Scoreboard: mirrors the cipher registers and holds pending results
   class cipher_tracker;
      logic [7:0]      nl_reg;
      logic [7:0]      lin_reg;
      step_result_type expected_steps[$];
      int              errors;

      function new();
         nl_reg  = '0;
         lin_reg = '0;
         errors  = 0;
      endfunction

      // Cell i sits at bit 7-i
      function logic filter_bit(logic [7:0] n, logic [7:0] l);
         return (n[3] & l[5]) ^ (n[0] & l[1]) ^ n[5] ^ n[3] ^ n[0] ^ l[2];
      endfunction

      function logic nl_feedback(logic [7:0] n);
         return n[7] ^ n[5] ^ n[4] ^ (n[4] & n[2]) ^ (n[6] & n[5]) ^ (n[3] & n[1]);
      endfunction

      // Advance the mirrored state for one accepted transaction
      function void predict_step(op_type op, logic [7:0] key, logic [3:0] iv);
         step_result_type r;
         logic            h;
         logic            nb;
         logic            lb;
         logic            l0;
         logic            n0;
         logic [7:0]      ns;
         logic [7:0]      ls;
         h = 1'b0;
         case (op)
            OP_LOAD: begin
               nl_reg  = key;
               lin_reg = {iv, LIN_TAIL};
            end
            OP_INVERSE: begin
               // shift toward cell 7, cell 0 kept until rebuilt
               ns = {nl_reg[7], nl_reg[7:1]};
               ls = {lin_reg[7], lin_reg[7:1]};
               h  = filter_bit(ns, ls);
               l0 = h ^ lin_reg[0] ^ ls[6] ^ ls[1] ^ ls[0];
               // feedback without its cell 0 term
               n0 = h ^ nl_reg[0] ^ l0 ^ nl_feedback(ns) ^ ns[7];
               nl_reg  = {n0, ns[6:0]};
               lin_reg = {l0, ls[6:0]};
            end
            default: begin
               h  = filter_bit(nl_reg, lin_reg);
               nb = nl_feedback(nl_reg) ^ lin_reg[7];
               lb = lin_reg[7] ^ lin_reg[6] ^ lin_reg[1] ^ lin_reg[0];
               if (op == OP_INIT) begin
                  nb = nb ^ h;
                  lb = lb ^ h;
               end
               nl_reg  = {nl_reg[6:0], nb};
               lin_reg = {lin_reg[6:0], lb};
            end
         endcase
         r.ks             = h;
         r.regs.nonlinear = nl_reg;
         r.regs.linear    = lin_reg;
         expected_steps.push_back(r);
      endfunction

      task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
         errors++;
         $display("[%0t] mismatch %s: got %02h want %02h", $realtime, what, got, want);
      endtask

      // Compare one result transaction with the oldest pending one
      task check_step(logic ks, logic [7:0] nl, logic [7:0] lin);
         step_result_type want;
         if (expected_steps.size() == 0) begin
            report_mismatch("result with none pending", nl, 8'hxx);
            return;
         end
         want = expected_steps.pop_front();
         if (ks !== want.ks)
            report_mismatch("keystream_bit", {7'd0, ks}, {7'd0, want.ks});
         if (nl !== want.regs.nonlinear)
            report_mismatch("nonlinear_state", nl, want.regs.nonlinear);
         if (lin !== want.regs.linear)
            report_mismatch("linear_state", lin, want.regs.linear);
      endtask
   endclass

   logic       clock               = 1'b0;
   logic       reset               = 1'b1;
   logic       req_valid           = 1'b0;
   logic       req_ready;
   logic [1:0] req_operation       = OP_LOAD;
   logic [7:0] req_key             = '0;
   logic [3:0] req_init_vector     = '0;
   logic       rsp_valid;
   logic       rsp_ready           = 1'b0;
   logic       rsp_keystream_bit;
   logic [7:0] rsp_nonlinear_state;
   logic [7:0] rsp_linear_state;

   bit            calm   = 1'b0;
   int            cycles = 0;
   cipher_tracker tracker = new();

   toy_grain_cipher_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_key             (req_key),
      .req_init_vector     (req_init_vector),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_keystream_bit   (rsp_keystream_bit),
      .rsp_nonlinear_state (rsp_nonlinear_state),
      .rsp_linear_state    (rsp_linear_state)
   );

   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stalls, none while calm
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_step(rsp_keystream_bit, rsp_nonlinear_state, rsp_linear_state);
   end

   // One request transaction; returns at the falling edge after acceptance
   task automatic send_step(op_type op, logic [7:0] key, logic [3:0] iv);
      // idle cycle by cycle, each with the same odds
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_key         <= key;
      req_init_vector <= iv;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.predict_step(op, key, iv);
      @(negedge clock);
   endtask

   // A clock op with junk in the ignored fields
   task automatic send_clock(op_type op);
      send_step(op, 8'($urandom_range(255)), 4'($urandom_range(15)));
   endtask

   initial begin
      int sent;
      int run;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: all-zero state, field extremes, every op, round trip
      send_clock(OP_KEYSTREAM);
      send_clock(OP_INVERSE);
      send_step(OP_LOAD, 8'h00, 4'h0);
      send_clock(OP_KEYSTREAM);
      send_clock(OP_INIT);
      send_clock(OP_INVERSE);
      send_step(OP_LOAD, 8'hff, 4'hf);
      repeat (3) send_clock(OP_INIT);
      repeat (3) send_clock(OP_INVERSE);
      repeat (2) send_clock(OP_KEYSTREAM);
      send_step(OP_LOAD, 8'ha5, 4'h9);
      send_clock(OP_KEYSTREAM);
      send_step(OP_LOAD, 8'h5a, 4'h6);
      send_clock(OP_INVERSE);
      send_step(OP_LOAD, 8'h00, 4'hf);
      send_clock(OP_INIT);
      send_step(OP_LOAD, 8'hff, 4'h0);
      send_clock(OP_INVERSE);

      // Random: mostly load followed by a run of clocks, some loose ops
      sent = 0;
      while (sent < ITEM_COUNT) begin
         calm = (sent >= 250 && sent < 350);
         if ($urandom_range(99) < 85) begin
            send_step(OP_LOAD, 8'($urandom_range(255)), 4'($urandom_range(15)));
            run = $urandom_range(12, 1);
            if ($urandom_range(3) == 0) begin
               // init run undone by inverse run
               repeat (run) send_clock(OP_INIT);
               repeat (run) send_clock(OP_INVERSE);
               sent += 1 + 2 * run;
            end else begin
               repeat (run) send_clock(op_type'($urandom_range(3, 1)));
               sent += 1 + run;
            end
         end else begin
            send_step(op_type'($urandom_range(3)), 8'($urandom_range(255)),
                      4'($urandom_range(15)));
            sent++;
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle
      while (tracker.expected_steps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.expected_steps.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
